FILE: hdl/jti_pkg.sv
`timescale 1ns / 1ps
package jti_pkg;
   localparam int MAX_WAYPOINTS_DEF = 64;
   localparam int JOINTS_DEF = 7;
   localparam int POS_WIDTH_DEF = 20;
   localparam int TIME_WIDTH = 26;
   localparam int ELAPSED_WIDTH = 27;
   localparam int TICK_WIDTH = 20;
   localparam int HOLD_WIDTH = 8;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TICK_PERIOD = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HOLD_TICKS = 1'b1;
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   typedef struct packed {
      logic cmd;
      logic [TIME_WIDTH-1:0] waypoint_time_us;
      logic signed [POS_WIDTH_DEF-1:0] joint_in0;
      logic signed [POS_WIDTH_DEF-1:0] joint_in1;
      logic signed [POS_WIDTH_DEF-1:0] joint_in2;
      logic signed [POS_WIDTH_DEF-1:0] joint_in3;
      logic signed [POS_WIDTH_DEF-1:0] joint_in4;
      logic signed [POS_WIDTH_DEF-1:0] joint_in5;
      logic signed [POS_WIDTH_DEF-1:0] joint_in6;
      logic last_waypoint;
   } req_type;

   typedef struct packed {
      logic signed [POS_WIDTH_DEF-1:0] joint_out0;
      logic signed [POS_WIDTH_DEF-1:0] joint_out1;
      logic signed [POS_WIDTH_DEF-1:0] joint_out2;
      logic signed [POS_WIDTH_DEF-1:0] joint_out3;
      logic signed [POS_WIDTH_DEF-1:0] joint_out4;
      logic signed [POS_WIDTH_DEF-1:0] joint_out5;
      logic signed [POS_WIDTH_DEF-1:0] joint_out6;
      logic phase;
      logic last_hold;
   } rsp_type;

   // Interpolation job handed to every lane.
   typedef struct packed {
      logic start;
      logic [ELAPSED_WIDTH-1:0] num_t;
      logic [ELAPSED_WIDTH-1:0] den_t;
   } lane_cmd_type;
endpackage

FILE: hdl/jti_ram.sv
`timescale 1ns / 1ps
module jti_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

FILE: hdl/jti_lane.sv
`timescale 1ns / 1ps
module jti_lane #(
   parameter int POS_WIDTH = jti_pkg::POS_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  jti_pkg::lane_cmd_type       lane_cmd,
   input  logic signed [POS_WIDTH-1:0] p0,
   input  logic signed [POS_WIDTH-1:0] p1,
   output logic signed [POS_WIDTH-1:0] q,
   output logic                        done
);
   import jti_pkg::*;

   // One lane: multiply d*(t-t0) once, then restoring division one bit a cycle.
   localparam int DW = POS_WIDTH + 1;
   localparam int PW = DW + ELAPSED_WIDTH;
   localparam int CW = $clog2(PW + 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_FIX  = 3'b100
   } lane_state_type;

   lane_state_type step_ff, step_in;
   logic [PW-1:0] mag_ff, mag_in;
   logic [PW-1:0] quo_ff, quo_in;
   logic [ELAPSED_WIDTH:0] rem_ff, rem_in;
   logic [ELAPSED_WIDTH-1:0] den_ff, den_in;
   logic neg_ff, neg_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic signed [POS_WIDTH-1:0] q_ff, q_in;
   logic signed [DW-1:0] d;
   logic signed [PW:0] prod;
   logic [ELAPSED_WIDTH:0] trial;
   logic signed [PW:0] sum;

   assign d = DW'(p1) - DW'(p0);
   assign prod = (PW+1)'(d) * $signed({1'b0, lane_cmd.num_t});
   assign trial = {rem_ff[ELAPSED_WIDTH-1:0], mag_ff[PW-1]};
   assign sum = (PW+1)'(p0) + (neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff}));

   always_comb begin
      step_in = step_ff; mag_in = mag_ff; quo_in = quo_ff; rem_in = rem_ff;
      den_in = den_ff; neg_in = neg_ff; cnt_in = cnt_ff; q_in = q_ff;
      case (step_ff)
         ST_IDLE: begin
            if (lane_cmd.start) begin
               neg_in = prod[PW];
               mag_in = prod[PW] ? PW'(-prod) : prod[PW-1:0];
               mag_in = mag_in + PW'(lane_cmd.den_t >> 1);
               den_in = lane_cmd.den_t;
               rem_in = '0; quo_in = '0;
               cnt_in = CW'(PW);
               step_in = ST_DIV;
            end
         end
         ST_DIV: begin
            mag_in = mag_ff << 1;
            if (trial >= {1'b0, den_ff}) begin
               rem_in = trial - {1'b0, den_ff};
               quo_in = {quo_ff[PW-2:0], 1'b1};
            end else begin
               rem_in = trial;
               quo_in = {quo_ff[PW-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) step_in = ST_FIX;
         end
         ST_FIX: begin
            q_in = sum[POS_WIDTH-1:0];
            step_in = ST_IDLE;
         end
         default: step_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_IDLE;
         done <= 1'b0;
      end else begin
         step_ff <= step_in;
         done <= (step_ff == ST_FIX);
      end
      mag_ff <= mag_in; quo_ff <= quo_in; rem_ff <= rem_in; den_ff <= den_in;
      neg_ff <= neg_in; cnt_ff <= cnt_in; q_ff <= q_in;
   end
   assign q = q_ff;
endmodule

FILE: hdl/joint_trajectory_interpolator.sv
`timescale 1ns / 1ps
// A load is stored at its accepting edge. A tick steps through S_TOTAL, then S_SEEK and
// S_SEEKCK for each segment advanced, then S_POS and, when it interpolates, S_LANE, where
// the lanes' bit-serial dividers take one bit per cycle over the 48-bit product plus setup
// and rounding, then S_OUT; a holding tick goes through S_POS and S_OUT only. Loads go back
// to back; busy stays high until the tick's beat is out. Reset is synchronous and active high;
// it empties the waypoint list and restores the register defaults. The receiver cannot stall.
module joint_trajectory_interpolator #(
   parameter int MAX_WAYPOINTS = jti_pkg::MAX_WAYPOINTS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  jti_pkg::req_type                      req_data,
   output logic                                  rsp_strobe,
   output jti_pkg::rsp_type                      rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [jti_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [31:0]                           csr_wdata
);
   import jti_pkg::*;

   localparam int JOINTS = JOINTS_DEF;
   localparam int POS_WIDTH = POS_WIDTH_DEF;
   localparam int AW = $clog2(MAX_WAYPOINTS);
   localparam int NW = $clog2(MAX_WAYPOINTS + 1);
   localparam logic [ELAPSED_WIDTH-1:0] ELAPSED_MAX = '1;
   localparam logic [1:0] PICK_P0 = 2'd0;
   localparam logic [1:0] PICK_P1 = 2'd1;
   localparam logic [1:0] PICK_Q = 2'd2;

   typedef enum logic [3:0] {
      PH_IDLE = 4'b0001, PH_PLAY = 4'b0010, PH_HOLD = 4'b0100, PH_DONE = 4'b1000
   } play_type;

   typedef enum logic [6:0] {
      S_WAIT   = 7'b0000001,
      S_TOTAL  = 7'b0000010,
      S_SEEK   = 7'b0000100,
      S_SEEKCK = 7'b0001000,
      S_POS    = 7'b0010000,
      S_LANE   = 7'b0100000,
      S_OUT    = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   play_type play_ff, play_in;
   logic [NW-1:0] count_ff, count_in;
   logic [AW-1:0] seg_ff, seg_in;
   logic [ELAPSED_WIDTH-1:0] elapsed_ff, elapsed_in, t_ff, t_in;
   logic [HOLD_WIDTH-1:0] hold_cnt_ff, hold_cnt_in, hold_ticks_ff;
   logic [TICK_WIDTH-1:0] tick_period_ff;
   logic [TIME_WIDTH-1:0] t0_ff, t0_in;
   logic final_ff, final_in;
   logic strobe_ff, strobe_in;
   logic phase_ff, phase_in, last_ff, last_in;
   logic sel1_ff;

   // Stores: a time memory and one position memory per joint.
   logic t_we;
   logic [AW-1:0] t_waddr, t_raddr;
   logic [TIME_WIDTH-1:0] t_rdata;
   logic [AW-1:0] p_raddr;
   logic [POS_WIDTH-1:0] p_rdata [JOINTS];
   logic [POS_WIDTH-1:0] wpos [JOINTS];
   logic signed [POS_WIDTH-1:0] p0_ff [JOINTS];
   logic signed [POS_WIDTH-1:0] p1_ff [JOINTS];
   logic signed [POS_WIDTH-1:0] q_out [JOINTS];
   logic signed [POS_WIDTH-1:0] res_ff [JOINTS];
   logic lane_done [JOINTS];
   lane_cmd_type lane_cmd;
   logic lane_go_ff, lane_go_in;
   logic [ELAPSED_WIDTH-1:0] num_ff, num_in, den_ff, den_in;

   logic [POS_WIDTH_DEF-1:0] in_pos [7];
   assign in_pos[0] = req_data.joint_in0; assign in_pos[1] = req_data.joint_in1;
   assign in_pos[2] = req_data.joint_in2; assign in_pos[3] = req_data.joint_in3;
   assign in_pos[4] = req_data.joint_in4; assign in_pos[5] = req_data.joint_in5;
   assign in_pos[6] = req_data.joint_in6;

   logic accept, is_load, will_store;
   assign accept = start && !busy;
   assign is_load = accept && (req_data.cmd == CMD_LOAD);
   logic [NW-1:0] base_cnt;
   assign base_cnt = (play_ff != PH_IDLE) ? '0 : count_ff;
   assign will_store = is_load && (base_cnt < NW'(MAX_WAYPOINTS));
   assign t_we = will_store;
   assign t_waddr = base_cnt[AW-1:0];

   jti_ram #(.WIDTH(TIME_WIDTH), .DEPTH(MAX_WAYPOINTS)) u_time_ram (
      .clock(clock), .wr_en(t_we), .wr_addr(t_waddr), .wr_data(req_data.waypoint_time_us),
      .rd_addr(t_raddr), .rd_data(t_rdata));

   for (genvar j = 0; j < JOINTS; j++) begin : g_lane
      assign wpos[j] = in_pos[j];
      jti_ram #(.WIDTH(POS_WIDTH), .DEPTH(MAX_WAYPOINTS)) u_pos_ram (
         .clock(clock), .wr_en(t_we), .wr_addr(t_waddr), .wr_data(wpos[j]),
         .rd_addr(p_raddr), .rd_data(p_rdata[j]));
      jti_lane #(.POS_WIDTH(POS_WIDTH)) u_lane (
         .clock(clock), .reset(reset), .lane_cmd(lane_cmd),
         .p0(p0_ff[j]), .p1(p1_ff[j]), .q(q_out[j]), .done(lane_done[j]));
   end

   assign lane_cmd.start = lane_go_ff;
   assign lane_cmd.num_t = num_ff;
   assign lane_cmd.den_t = den_ff;

   // Read-address steering. The time memory is addressed in the state before the one that uses its data.
   logic [AW-1:0] last_idx;
   assign last_idx = AW'(count_ff - 1'b1);
   logic seg_has_next;
   assign seg_has_next = (NW'(seg_ff) + 1'b1) < count_ff;
   logic [AW-1:0] seg_next;
   assign seg_next = seg_ff + 1'b1;

   logic [1:0] pos_step_ff, pos_step_in;

   always_comb begin
      t_raddr = last_idx;
      p_raddr = seg_ff;
      case (state_ff)
         S_TOTAL:  t_raddr = seg_next;
         S_SEEK:   t_raddr = seg_next;
         S_SEEKCK: t_raddr = seg_next;
         S_POS:    begin
            t_raddr = (pos_step_ff == 2'd0) ? seg_ff : seg_next;
            p_raddr = final_ff ? last_idx : ((pos_step_ff == 2'd0) ? seg_ff : seg_next);
         end
         default: ;
      endcase
   end

   logic [ELAPSED_WIDTH:0] sum_t;
   assign sum_t = {1'b0, elapsed_ff} + (ELAPSED_WIDTH+1)'(tick_period_ff);

   logic hold_last;
   always_comb begin
      state_in = state_ff; play_in = play_ff; count_in = count_ff; seg_in = seg_ff;
      elapsed_in = elapsed_ff; t_in = t_ff; hold_cnt_in = hold_cnt_ff; t0_in = t0_ff;
      final_in = final_ff; strobe_in = 1'b0; phase_in = phase_ff; last_in = last_ff;
      lane_go_in = 1'b0; num_in = num_ff; den_in = den_ff; pos_step_in = pos_step_ff;
      hold_last = 1'b0;
      case (state_ff)
         S_WAIT: begin
            if (is_load) begin
               count_in = will_store ? base_cnt + 1'b1 : base_cnt;
               play_in = PH_IDLE;
               if (req_data.last_waypoint && (count_in != '0)) begin
                  play_in = PH_PLAY; seg_in = '0; elapsed_in = '0; hold_cnt_in = '0;
               end
            end else if (accept && count_ff != '0) begin
               if (play_ff == PH_PLAY) begin
                  t_in = elapsed_ff;
                  elapsed_in = sum_t[ELAPSED_WIDTH] ? ELAPSED_MAX : sum_t[ELAPSED_WIDTH-1:0];
                  state_in = S_TOTAL;
               end else if (play_ff == PH_HOLD) begin
                  state_in = S_OUT; final_in = 1'b1; phase_in = 1'b1;
                  pos_step_in = 2'd0; state_in = S_POS;
               end
            end
         end
         S_TOTAL: begin
            // t_rdata holds the last waypoint's time.
            if (t_ff > ELAPSED_WIDTH'(t_rdata)) begin
               play_in = PH_HOLD; hold_cnt_in = '0; phase_in = 1'b1; final_in = 1'b1;
               pos_step_in = 2'd0; state_in = S_POS;
            end else begin
               state_in = S_SEEK;
            end
         end
         S_SEEK: state_in = S_SEEKCK;
         S_SEEKCK: begin
            // t_rdata is the time of the waypoint after the segment.
            if (seg_has_next && ELAPSED_WIDTH'(t_rdata) < t_ff) begin
               seg_in = seg_next; state_in = S_SEEK;
            end else begin
               phase_in = 1'b0; final_in = !seg_has_next;
               pos_step_in = 2'd0; state_in = S_POS;
            end
         end
         S_POS: begin
            pos_step_in = pos_step_ff + 1'b1;
            if (pos_step_ff == 2'd1) t0_in = t_rdata;
            if (pos_step_ff == 2'd2) begin
               if (final_ff) begin
                  state_in = S_OUT;
               end else begin
                  num_in = (t_ff > ELAPSED_WIDTH'(t0_ff)) ? t_ff - ELAPSED_WIDTH'(t0_ff) : '0;
                  den_in = ELAPSED_WIDTH'(t_rdata) - ELAPSED_WIDTH'(t0_ff);
                  state_in = S_LANE;
                  if (ELAPSED_WIDTH'(t_rdata) <= ELAPSED_WIDTH'(t0_ff)
                      || t_ff <= ELAPSED_WIDTH'(t0_ff)) begin
                     final_in = 1'b0; state_in = S_OUT;
                  end else if (t_ff >= ELAPSED_WIDTH'(t_rdata)) begin
                     state_in = S_OUT;
                  end else begin
                     lane_go_in = 1'b1;
                  end
               end
            end
         end
         S_LANE: if (lane_done[0]) state_in = S_OUT;
         S_OUT: begin
            state_in = S_WAIT;
            last_in = 1'b0;
            if (play_ff == PH_HOLD) begin
               if (hold_cnt_ff >= hold_ticks_ff) begin
                  play_in = PH_DONE;
               end else begin
                  hold_cnt_in = hold_cnt_ff + 1'b1;
                  hold_last = (hold_cnt_in >= hold_ticks_ff);
                  last_in = hold_last;
                  if (hold_last) play_in = PH_DONE;
                  strobe_in = 1'b1;
               end
            end else begin
               strobe_in = 1'b1;
            end
         end
         default: state_in = S_WAIT;
      endcase
   end

   // Output selection: p0 for clamped segments, p1 at or past the segment end, else the lanes' q.
   logic [1:0] pick_ff, pick_in;
   always_comb begin
      pick_in = pick_ff;
      if (state_ff == S_POS && pos_step_ff == 2'd2) begin
         if (final_ff) pick_in = PICK_P1;
         else if (ELAPSED_WIDTH'(t_rdata) <= ELAPSED_WIDTH'(t0_ff)
                  || t_ff <= ELAPSED_WIDTH'(t0_ff)) pick_in = PICK_P0;
         else if (t_ff >= ELAPSED_WIDTH'(t_rdata)) pick_in = PICK_P1;
         else pick_in = PICK_Q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_WAIT; play_ff <= PH_IDLE; count_ff <= '0; seg_ff <= '0;
         elapsed_ff <= '0; hold_cnt_ff <= '0; strobe_ff <= 1'b0; lane_go_ff <= 1'b0;
         tick_period_ff <= TICK_WIDTH'(10000); hold_ticks_ff <= HOLD_WIDTH'(50);
      end else begin
         state_ff <= state_in; play_ff <= play_in; count_ff <= count_in; seg_ff <= seg_in;
         elapsed_ff <= elapsed_in; hold_cnt_ff <= hold_cnt_in; strobe_ff <= strobe_in;
         lane_go_ff <= lane_go_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TICK_PERIOD: tick_period_ff <= csr_wdata[TICK_WIDTH-1:0];
               CSR_HOLD_TICKS:  hold_ticks_ff <= csr_wdata[HOLD_WIDTH-1:0];
               default: ;
            endcase
         end
      end
      t_ff <= t_in; t0_ff <= t0_in; final_ff <= final_in; phase_ff <= phase_in;
      last_ff <= last_in; num_ff <= num_in; den_ff <= den_in; pos_step_ff <= pos_step_in;
      pick_ff <= pick_in;
      sel1_ff <= (state_ff == S_POS) && (pos_step_ff == 2'd1);
      for (int j = 0; j < JOINTS; j++) begin
         if (state_ff == S_POS && pos_step_ff == 2'd1) p0_ff[j] <= p_rdata[j];
         if (state_ff == S_POS && pos_step_ff == 2'd2) p1_ff[j] <= p_rdata[j];
         if (state_ff == S_OUT) begin
            case (pick_ff)
               PICK_P0: res_ff[j] <= p0_ff[j];
               PICK_P1: res_ff[j] <= final_ff ? p0_ff[j] : p1_ff[j];
               default: res_ff[j] <= q_out[j];
            endcase
         end
      end
   end

   // In final mode both reads address the last waypoint, so p0 holds the final row.
   assign busy = (state_ff != S_WAIT) || strobe_ff || sel1_ff;
   // Registers are only taken between items, so a tick never sees them change.
   assign csr_ready = !busy;
   assign rsp_strobe = strobe_ff;

   logic [POS_WIDTH_DEF-1:0] o [7];
   for (genvar k = 0; k < 7; k++) begin : g_out
      if (k < JOINTS) begin : g_on
         assign o[k] = POS_WIDTH_DEF'(res_ff[k]);
      end else begin : g_off
         assign o[k] = '0;
      end
   end
   assign rsp_data.joint_out0 = o[0]; assign rsp_data.joint_out1 = o[1];
   assign rsp_data.joint_out2 = o[2]; assign rsp_data.joint_out3 = o[3];
   assign rsp_data.joint_out4 = o[4]; assign rsp_data.joint_out5 = o[5];
   assign rsp_data.joint_out6 = o[6];
   assign rsp_data.phase = phase_ff;
   assign rsp_data.last_hold = last_ff;
endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import jti_pkg::*;

   localparam int NJ = JOINTS_DEF;
   localparam int DEPTH = MAX_WAYPOINTS_DEF;
   localparam int RANDOM_ITEMS = 500;
   localparam int unsigned ELAPSED_SAT = (1 << ELAPSED_WIDTH) - 1;
   // A tick may seek through every stored segment and then wait on the lanes' dividers.
   localparam int SETTLE_CYCLES = 200;

   typedef logic signed [POS_WIDTH_DEF-1:0] joint_vec_type [NJ];
   typedef enum logic [1:0] {PLAY_IDLE, PLAY_RUN, PLAY_HOLD, PLAY_DONE} play_state_type;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_type req_data;
   logic rsp_strobe;
   rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [31:0] csr_wdata;

   joint_trajectory_interpolator dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Mirror of the player: waypoint store, playback state and registers.
   int unsigned wp_time [DEPTH];
   logic signed [POS_WIDTH_DEF-1:0] wp_pos [DEPTH][NJ];
   int unsigned wp_count;
   int unsigned seg;
   int unsigned elapsed;
   int unsigned hold_cnt;
   play_state_type play_state;
   int unsigned tick_period;
   int unsigned hold_limit;

   rsp_type expected_beats [$];
   int errors;
   int items_sent;
   int beats_checked;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("CHECK FAILED");
      $finish;
   end

   // Rounded linear interpolation, ties away from zero.
   function automatic logic signed [POS_WIDTH_DEF-1:0] lerp(
      logic signed [POS_WIDTH_DEF-1:0] p0, logic signed [POS_WIDTH_DEF-1:0] p1,
      int unsigned t, int unsigned t0, int unsigned t1);
      longint num;
      longint den;
      longint mag;
      longint q;
      if (t1 <= t0 || t <= t0) return p0;
      if (t >= t1) return p1;
      num = (longint'(p1) - longint'(p0)) * longint'(t - t0);
      den = longint'(t1 - t0);
      mag = num < 0 ? -num : num;
      q = (mag + den / 2) / den;
      if (num < 0) q = -q;
      return POS_WIDTH_DEF'(longint'(p0) + q);
   endfunction

   function automatic rsp_type pack_beat(joint_vec_type j, logic ph, logic lst);
      rsp_type r;
      r.joint_out0 = j[0];
      r.joint_out1 = j[1];
      r.joint_out2 = j[2];
      r.joint_out3 = j[3];
      r.joint_out4 = j[4];
      r.joint_out5 = j[5];
      r.joint_out6 = j[6];
      r.phase = ph;
      r.last_hold = lst;
      return r;
   endfunction

   // Appends one predicted beat at the tail of the queue.
   task automatic queue_beat(rsp_type r);
      expected_beats.insert(expected_beats.size(), r);
   endtask

   task automatic expect_final(logic ph, logic lst);
      joint_vec_type j;
      for (int k = 0; k < NJ; k++) j[k] = wp_pos[wp_count - 1][k];
      queue_beat(pack_beat(j, ph, lst));
   endtask

   task automatic hold_step();
      if (hold_cnt >= hold_limit) begin
         play_state = PLAY_DONE;
         return;
      end
      hold_cnt++;
      expect_final(1'b1, hold_cnt >= hold_limit);
      if (hold_cnt >= hold_limit) play_state = PLAY_DONE;
   endtask

   task automatic play_step();
      int unsigned t;
      int unsigned sum;
      joint_vec_type j;
      t = elapsed;
      sum = t + tick_period;
      elapsed = sum > ELAPSED_SAT ? ELAPSED_SAT : sum;
      if (t > wp_time[wp_count - 1]) begin
         play_state = PLAY_HOLD;
         hold_cnt = 0;
         hold_step();
         return;
      end
      while (seg + 1 < wp_count && wp_time[seg + 1] < t) seg++;
      if (seg + 1 >= wp_count) begin
         expect_final(1'b0, 1'b0);
         return;
      end
      for (int k = 0; k < NJ; k++)
         j[k] = lerp(wp_pos[seg][k], wp_pos[seg + 1][k], t, wp_time[seg], wp_time[seg + 1]);
      queue_beat(pack_beat(j, 1'b0, 1'b0));
   endtask

   // Advances the mirror by one accepted item and queues any beat it causes.
   task automatic predict_trajectory(req_type it);
      if (it.cmd == CMD_LOAD) begin
         if (play_state != PLAY_IDLE) begin
            wp_count = 0;
            play_state = PLAY_IDLE;
         end
         if (wp_count < DEPTH) begin
            wp_time[wp_count] = it.waypoint_time_us;
            wp_pos[wp_count][0] = it.joint_in0;
            wp_pos[wp_count][1] = it.joint_in1;
            wp_pos[wp_count][2] = it.joint_in2;
            wp_pos[wp_count][3] = it.joint_in3;
            wp_pos[wp_count][4] = it.joint_in4;
            wp_pos[wp_count][5] = it.joint_in5;
            wp_pos[wp_count][6] = it.joint_in6;
            wp_count++;
         end
         if (it.last_waypoint && wp_count > 0) begin
            play_state = PLAY_RUN;
            seg = 0;
            elapsed = 0;
            hold_cnt = 0;
         end
      end else if (wp_count != 0) begin
         if (play_state == PLAY_RUN) play_step();
         else if (play_state == PLAY_HOLD) hold_step();
      end
   endtask

   // Mostly back to back, sometimes a short gap, rarely a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 19);
      if (r < 12) return 0;
      if (r < 18) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Sends one item. Start stays high only when the next item follows at once.
   task automatic send_item(req_type it);
      int gap;
      req_data <= it;
      if (!start) start <= 1'b1;
      do @(posedge clock); while (busy);
      predict_trajectory(it);
      items_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic stop_items();
      if (start) start <= 1'b0;
   endtask

   function automatic logic signed [POS_WIDTH_DEF-1:0] rand_joint();
      case ($urandom_range(0, 7))
         0: return {1'b1, {(POS_WIDTH_DEF - 1){1'b0}}};
         1: return {1'b0, {(POS_WIDTH_DEF - 1){1'b1}}};
         default: return POS_WIDTH_DEF'($urandom);
      endcase
   endfunction

   task automatic load_point(int unsigned t, logic lst);
      req_type it;
      it.cmd = CMD_LOAD;
      it.waypoint_time_us = t[TIME_WIDTH-1:0];
      it.joint_in0 = rand_joint();
      it.joint_in1 = rand_joint();
      it.joint_in2 = rand_joint();
      it.joint_in3 = rand_joint();
      it.joint_in4 = rand_joint();
      it.joint_in5 = rand_joint();
      it.joint_in6 = rand_joint();
      it.last_waypoint = lst;
      send_item(it);
   endtask

   // A tick carries random payload bits that the block must ignore.
   task automatic tick();
      req_type it;
      it = req_type'({$urandom, $urandom, $urandom, $urandom, $urandom});
      it.cmd = CMD_TICK;
      send_item(it);
   endtask

   // Waits until every queued beat has come and any silent tick has finished.
   task automatic settle();
      stop_items();
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_WIDTH-1:0] idx, int unsigned value);
      settle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_TICK_PERIOD) tick_period = value & 32'hFFFFF;
      else hold_limit = value & 32'hFF;
   endtask

   task automatic check_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
         errors++;
      end
   endtask

   // Every strobed beat is matched against the oldest predicted beat.
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_strobe) begin
         if (expected_beats.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual %h", $time, rsp_data);
            errors++;
         end else begin
            e = expected_beats.pop_front();
            beats_checked++;
            check_field("joint_out0", e.joint_out0, rsp_data.joint_out0);
            check_field("joint_out1", e.joint_out1, rsp_data.joint_out1);
            check_field("joint_out2", e.joint_out2, rsp_data.joint_out2);
            check_field("joint_out3", e.joint_out3, rsp_data.joint_out3);
            check_field("joint_out4", e.joint_out4, rsp_data.joint_out4);
            check_field("joint_out5", e.joint_out5, rsp_data.joint_out5);
            check_field("joint_out6", e.joint_out6, rsp_data.joint_out6);
            check_field("phase", e.phase, rsp_data.phase);
            check_field("last_hold", e.last_hold, rsp_data.last_hold);
         end
      end
   end

   // Ticks with nothing loaded must stay silent, with the reset register values.
   task automatic test_empty_ticks();
      tick();
      tick();
   endtask

   // Extreme positions, a zero length segment, a decreasing time and the
   // segment sitting on the last waypoint before the end time is passed.
   task automatic test_basic_trajectory();
      write_reg(CSR_TICK_PERIOD, 7);
      write_reg(CSR_HOLD_TICKS, 3);
      load_point(0, 1'b0);
      load_point(10, 1'b0);
      load_point(10, 1'b0);
      load_point(4, 1'b0);
      load_point(30, 1'b1);
      repeat (11) tick();
   endtask

   // A load while playing drops the list; without a last mark the block idles.
   task automatic test_reload_while_playing();
      load_point(0, 1'b0);
      load_point(100, 1'b1);
      tick();
      tick();
      load_point(5, 1'b0);
      tick();
      load_point(50, 1'b1);
      repeat (3) tick();
   endtask

   // The sixty-fifth load is dropped but its last mark still starts playback.
   task automatic test_store_full();
      write_reg(CSR_TICK_PERIOD, 1);
      for (int k = 0; k <= DEPTH; k++) load_point(k, k == DEPTH);
      repeat (4) tick();
   endtask

   // With a zero hold count the tick that passes the end is silent.
   task automatic test_zero_hold();
      write_reg(CSR_HOLD_TICKS, 0);
      load_point(0, 1'b1);
      repeat (3) tick();
   endtask

   // Lowering the hold count while holding ends the hold at once.
   task automatic test_hold_change();
      write_reg(CSR_HOLD_TICKS, 5);
      write_reg(CSR_TICK_PERIOD, 10);
      load_point(0, 1'b1);
      repeat (3) tick();
      write_reg(CSR_HOLD_TICKS, 1);
      repeat (2) tick();
      write_reg(CSR_HOLD_TICKS, 255);
      load_point(0, 1'b1);
      repeat (258) tick();
   endtask

   // A zero period never moves time, so playback never leaves the start.
   task automatic test_zero_period();
      write_reg(CSR_TICK_PERIOD, 0);
      load_point(0, 1'b0);
      load_point(1000, 1'b1);
      repeat (3) tick();
   endtask

   // Largest times and periods, including the all ones time.
   task automatic test_long_times();
      write_reg(CSR_TICK_PERIOD, (1 << TICK_WIDTH) - 1);
      write_reg(CSR_HOLD_TICKS, 2);
      load_point(0, 1'b0);
      load_point(33554432, 1'b0);
      load_point((1 << TIME_WIDTH) - 1, 1'b1);
      repeat (68) tick();
   endtask

   // Well formed trajectories with random content, mixed with stray ticks,
   // lists left without a last mark and reloads in the middle of playback.
   task automatic test_random_trajectories();
      int n;
      int unsigned t;
      int unsigned span;
      int ticks;
      int wide;
      while (items_sent < RANDOM_ITEMS) begin
         wide = ($urandom_range(0, 9) == 0);
         if ($urandom_range(0, 3) == 0) begin
            if (wide) write_reg(CSR_TICK_PERIOD, $urandom_range(500000, (1 << TICK_WIDTH) - 1));
            else write_reg(CSR_TICK_PERIOD, $urandom_range(1, 400));
            write_reg(CSR_HOLD_TICKS, $urandom_range(0, 4));
         end
         n = $urandom_range(1, 6);
         t = $urandom_range(0, 1) ? 0 : $urandom_range(0, 3 * tick_period + 3);
         for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 15) == 0) tick();
            load_point(wide ? $urandom & ((1 << TIME_WIDTH) - 1) : t,
                       k == n - 1 && $urandom_range(0, 19) != 0);
            case ($urandom_range(0, 7))
               0: span = 0;
               1: span = -$urandom_range(0, tick_period);
               default: span = $urandom_range(1, 4 * tick_period + 4);
            endcase
            t = (t + span) & ((1 << TIME_WIDTH) - 1);
         end
         ticks = (tick_period == 0) ? 4 : wp_time[wp_count - 1] / tick_period + hold_limit + 3;
         if (ticks > 70) ticks = 70;
         if ($urandom_range(0, 9) == 0) ticks = $urandom_range(0, ticks);
         repeat (ticks) tick();
      end
   endtask

   initial begin
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = CSR_TICK_PERIOD;
      csr_wdata = '0;
      errors = 0;
      items_sent = 0;
      beats_checked = 0;
      wp_count = 0;
      seg = 0;
      elapsed = 0;
      hold_cnt = 0;
      play_state = PLAY_IDLE;
      tick_period = 10000;
      hold_limit = 50;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_ticks();
      test_basic_trajectory();
      test_reload_while_playing();
      test_store_full();
      test_zero_hold();
      test_hold_change();
      test_zero_period();
      test_long_times();
      test_random_trajectories();

      settle();
      if (expected_beats.size() != 0) begin
         $display("%0t: %0d predicted beats never arrived", $time, expected_beats.size());
         errors++;
      end
      $display("Sent %0d loads and ticks over varied periods and hold counts,", items_sent);
      $display("and compared %0d trajectory beats field by field.", beats_checked);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
